>>> src/svpwm_pkg.sv
// Shared widths, constants, sector codes and the front-to-back transaction type
// for the space vector PWM timing unit. No dependencies.
package svpwm_pkg;

  localparam int IN_W       = 16;
  localparam int PERIOD_W   = 15;
  localparam int Q15_SHIFT  = 15;
  localparam int PROD_W     = 31;
  localparam int ALPHA_S_W  = PROD_W - Q15_SHIFT;
  localparam int VR_W       = 18;
  localparam int XY_W       = 16;
  localparam int WIDE_W     = PERIOD_W + XY_W;
  localparam int SUM_W      = WIDE_W + 1;
  localparam int S_W        = SUM_W - Q15_SHIFT;
  localparam int DIFF_W     = S_W + 1;
  localparam int DUTY_W     = 16;
  localparam int SECTOR_W   = 3;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic signed [IN_W-1:0] SQRT3_HALF_Q15 = 16'sd28378;

  localparam logic [SECTOR_W-1:0] SECTOR_1 = 3'd1;
  localparam logic [SECTOR_W-1:0] SECTOR_2 = 3'd2;
  localparam logic [SECTOR_W-1:0] SECTOR_3 = 3'd3;
  localparam logic [SECTOR_W-1:0] SECTOR_4 = 3'd4;
  localparam logic [SECTOR_W-1:0] SECTOR_5 = 3'd5;
  localparam logic [SECTOR_W-1:0] SECTOR_6 = 3'd6;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [XY_W-1:0]     x;
    logic [XY_W-1:0]     y;
  } svpwm_cls_t;

endpackage

>>> src/svpwm_ifs.sv
// Valid/ready channel interfaces for voltage demands, compare results and
// period configuration. Depends on svpwm_pkg.
interface svpwm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [svpwm_pkg::IN_W-1:0]     v_alpha;
  logic signed [svpwm_pkg::IN_W-1:0]     v_beta;
  modport source(output valid, output v_alpha, output v_beta, input ready);
  modport sink(input valid, input v_alpha, input v_beta, output ready);
endinterface

interface svpwm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [svpwm_pkg::DUTY_W-1:0]          duty_a;
  logic [svpwm_pkg::DUTY_W-1:0]          duty_b;
  logic [svpwm_pkg::DUTY_W-1:0]          duty_c;
  logic [svpwm_pkg::SECTOR_W-1:0]        sector_number;
  logic                                  overmodulated;
  modport source(output valid, output duty_a, output duty_b, output duty_c,
                 output sector_number, output overmodulated, input ready);
  modport sink(input valid, input duty_a, input duty_b, input duty_c,
               input sector_number, input overmodulated, output ready);
endinterface

interface svpwm_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [svpwm_pkg::PERIOD_W-1:0]        timer_period;
  modport source(output valid, output timer_period, input ready);
  modport sink(input valid, input timer_period, output ready);
endinterface

>>> src/space_vector_pwm_timing_unit.sv
// Space vector PWM timing unit, center-aligned compare values from alpha/beta.
// A transaction passes two front stages, one queue slot and two back stages into the
// output register before its result is valid.
// Throughput: one transaction per cycle unless held by back-pressure from out_ch.ready.
// Reset clears all valid flags, empties the queue and sets the timer period to 0.
module space_vector_pwm_timing_unit #(
  parameter int QUEUE_DEPTH = svpwm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  svpwm_cfg_if.sink     cfg_ch,
  svpwm_in_if.sink      in_ch,
  svpwm_out_if.source   out_ch
);
  import svpwm_pkg::*;

  localparam int CLS_W = $bits(svpwm_cls_t);

  logic [PERIOD_W-1:0] period_r;
  logic                f_valid;
  logic                f_ready;
  svpwm_cls_t          f_data;
  logic                q_valid;
  logic                q_ready;
  logic [CLS_W-1:0]    q_data;
  svpwm_cls_t          q_cls;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
    end else if (cfg_ch.valid) begin
      period_r <= cfg_ch.timer_period;
    end
  end

  svpwm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cls_valid (f_valid),
    .cls_ready (f_ready),
    .cls_data  (f_data)
  );

  svpwm_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (CLS_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_cls = q_data;

  svpwm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cls_valid    (q_valid),
    .cls_ready    (q_ready),
    .cls_data     (q_cls),
    .timer_period (period_r),
    .out_ch       (out_ch)
  );

endmodule

>>> src/svpwm_front.sv
// Front end: scales alpha, forms the reference voltages and classifies the
// sector with its two active-vector magnitudes. Depends on svpwm_pkg, svpwm_ifs.
module svpwm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  svpwm_in_if.sink               in_ch,
  output logic                   cls_valid,
  input  logic                   cls_ready,
  output svpwm_pkg::svpwm_cls_t  cls_data
);
  import svpwm_pkg::*;

  logic                         s1_vld_r;
  logic                         s2_vld_r;
  logic                         s1_ready;
  logic                         s2_ready;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [PROD_W-1:0]     prod_nxt;
  logic signed [IN_W-1:0]       beta_r;
  logic signed [ALPHA_S_W-1:0]  alpha_s;
  logic signed [VR_W-1:0]       neg_beta;
  logic signed [VR_W-1:0]       hb;
  logic signed [VR_W-1:0]       vr1;
  logic signed [VR_W-1:0]       vr2;
  logic signed [VR_W-1:0]       vr3;
  logic signed [VR_W-1:0]       xv;
  logic signed [VR_W-1:0]       yv;
  logic [SECTOR_W-1:0]          sector;
  svpwm_cls_t                   cls_r;
  svpwm_cls_t                   cls_nxt;

  assign s2_ready    = !s2_vld_r || cls_ready;
  assign s1_ready    = !s1_vld_r || s2_ready;
  assign in_ch.ready = s1_ready;
  assign cls_valid   = s2_vld_r;
  assign cls_data    = cls_r;

  assign prod_nxt = PROD_W'(in_ch.v_alpha) * PROD_W'(SQRT3_HALF_Q15);

  assign alpha_s  = $signed(prod_r[PROD_W-1:Q15_SHIFT]);
  assign neg_beta = -VR_W'(beta_r);
  assign hb       = (neg_beta + $signed({{(VR_W-1){1'b0}}, neg_beta[VR_W-1]})) >>> 1;
  assign vr1      = VR_W'(beta_r);
  assign vr2      = hb + VR_W'(alpha_s);
  assign vr3      = hb - VR_W'(alpha_s);

  always_comb begin
    if (!vr1[VR_W-1]) begin
      if (!vr2[VR_W-1]) begin
        sector = SECTOR_1;
        xv     = vr2;
        yv     = vr1;
      end else if (!vr3[VR_W-1]) begin
        sector = SECTOR_3;
        xv     = vr1;
        yv     = vr3;
      end else begin
        sector = SECTOR_2;
        xv     = -vr2;
        yv     = -vr3;
      end
    end else begin
      if (!vr2[VR_W-1]) begin
        if (!vr3[VR_W-1]) begin
          sector = SECTOR_5;
          xv     = vr3;
          yv     = vr2;
        end else begin
          sector = SECTOR_6;
          xv     = -vr3;
          yv     = -vr1;
        end
      end else begin
        sector = SECTOR_4;
        xv     = -vr1;
        yv     = -vr2;
      end
    end
  end

  always_comb begin
    cls_nxt.sector = sector;
    cls_nxt.x      = xv[XY_W-1:0];
    cls_nxt.y      = yv[XY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_vld_r <= in_ch.valid;
      end
      if (s2_ready) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      prod_r <= prod_nxt;
      beta_r <= in_ch.v_beta;
    end
    if (s2_ready && s1_vld_r) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

>>> src/svpwm_fifo.sv
// Short transaction queue between the front and back ends.
// Depends on nothing but its parameters.
module svpwm_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 35
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r;
  logic [IDX_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  assign wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + IDX_W'(1);
  assign rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + IDX_W'(1);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> src/svpwm_back.sv
// Back end: scales the active magnitudes by the period, forms the center-aligned
// compare values and maps them onto phases. Depends on svpwm_pkg, svpwm_ifs.
module svpwm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cls_valid,
  output logic                            cls_ready,
  input  svpwm_pkg::svpwm_cls_t           cls_data,
  input  logic [svpwm_pkg::PERIOD_W-1:0]  timer_period,
  svpwm_out_if.source                     out_ch
);
  import svpwm_pkg::*;

  logic                        b1_vld_r;
  logic                        b2_vld_r;
  logic                        out_vld_r;
  logic                        b1_ready;
  logic                        b2_ready;
  logic                        out_ready;
  logic [WIDE_W-1:0]           xw_r;
  logic [WIDE_W-1:0]           yw_r;
  logic [PERIOD_W-1:0]         p_r;
  logic [SECTOR_W-1:0]         sec1_r;
  logic [SUM_W-1:0]            sum;
  logic [S_W-1:0]              s_val;
  logic signed [DIFF_W-1:0]    d_val;
  logic signed [DIFF_W-1:0]    tc_full;
  logic [DUTY_W-1:0]           tc_nxt;
  logic                        ovf_nxt;
  logic [DUTY_W-1:0]           tc_r;
  logic [DUTY_W-1:0]           xs_r;
  logic [DUTY_W-1:0]           ys_r;
  logic                        ovf_r;
  logic [SECTOR_W-1:0]         sec2_r;
  logic [DUTY_W-1:0]           tb;
  logic [DUTY_W-1:0]           ta;
  logic [DUTY_W-1:0]           da_nxt;
  logic [DUTY_W-1:0]           db_nxt;
  logic [DUTY_W-1:0]           dc_nxt;
  logic [DUTY_W-1:0]           da_r;
  logic [DUTY_W-1:0]           db_r;
  logic [DUTY_W-1:0]           dc_r;
  logic [SECTOR_W-1:0]         sec_out_r;
  logic                        ovf_out_r;

  assign out_ready = !out_vld_r || out_ch.ready;
  assign b2_ready  = !b2_vld_r || out_ready;
  assign b1_ready  = !b1_vld_r || b2_ready;
  assign cls_ready = b1_ready;

  assign sum     = {1'b0, xw_r} + {1'b0, yw_r};
  assign s_val   = sum[SUM_W-1:Q15_SHIFT];
  assign d_val   = $signed({{(DIFF_W-PERIOD_W){1'b0}}, p_r})
                 - $signed({{(DIFF_W-S_W){1'b0}}, s_val});
  assign tc_full = (d_val + $signed({{(DIFF_W-1){1'b0}}, d_val[DIFF_W-1]})) >>> 1;
  assign tc_nxt  = tc_full[DUTY_W-1:0];
  assign ovf_nxt = (s_val > {{(S_W-PERIOD_W){1'b0}}, p_r});

  assign tb = tc_r + ys_r;
  assign ta = tb + xs_r;

  always_comb begin
    case (sec2_r)
      SECTOR_1: begin
        da_nxt = ta;
        db_nxt = tb;
        dc_nxt = tc_r;
      end
      SECTOR_2: begin
        da_nxt = tb;
        db_nxt = ta;
        dc_nxt = tc_r;
      end
      SECTOR_3: begin
        da_nxt = tc_r;
        db_nxt = ta;
        dc_nxt = tb;
      end
      SECTOR_4: begin
        da_nxt = tc_r;
        db_nxt = tb;
        dc_nxt = ta;
      end
      SECTOR_5: begin
        da_nxt = tb;
        db_nxt = tc_r;
        dc_nxt = ta;
      end
      default: begin
        da_nxt = ta;
        db_nxt = tc_r;
        dc_nxt = tb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_vld_r <= cls_valid;
      end
      if (b2_ready) begin
        b2_vld_r <= b1_vld_r;
      end
      if (out_ready) begin
        out_vld_r <= b2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_ready && cls_valid) begin
      xw_r   <= WIDE_W'(timer_period) * WIDE_W'(cls_data.x);
      yw_r   <= WIDE_W'(timer_period) * WIDE_W'(cls_data.y);
      p_r    <= timer_period;
      sec1_r <= cls_data.sector;
    end
    if (b2_ready && b1_vld_r) begin
      tc_r   <= tc_nxt;
      xs_r   <= xw_r[WIDE_W-1:Q15_SHIFT];
      ys_r   <= yw_r[WIDE_W-1:Q15_SHIFT];
      ovf_r  <= ovf_nxt;
      sec2_r <= sec1_r;
    end
    if (out_ready && b2_vld_r) begin
      da_r      <= da_nxt;
      db_r      <= db_nxt;
      dc_r      <= dc_nxt;
      sec_out_r <= sec2_r;
      ovf_out_r <= ovf_r;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.duty_a        = da_r;
  assign out_ch.duty_b        = db_r;
  assign out_ch.duty_c        = dc_r;
  assign out_ch.sector_number = sec_out_r;
  assign out_ch.overmodulated = ovf_out_r;

endmodule

>>> bench/testbench.sv
// Self-checking bench for the space vector PWM timing unit: directed table, then
// random alpha/beta demands over several periods and handshake idle patterns.
// Depends on svpwm_pkg, the channel interfaces in svpwm_ifs.sv and the unit itself.
module testbench;
  import svpwm_pkg::*;

  localparam int DIRECTED_ROWS = 21;
  localparam int HOLD_LEN      = 150;
  localparam int QUIET_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 20;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty_a;
    logic [DUTY_W-1:0]   duty_b;
    logic [DUTY_W-1:0]   duty_c;
    logic [SECTOR_W-1:0] sector;
    logic                overmod;
  } duty_set_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]    period;
    logic signed [IN_W-1:0] alpha;
    logic signed [IN_W-1:0] beta;
    logic                   typed;
    duty_set_t              want;
  } demand_row_t;

  logic clk;
  logic rst_n;

  svpwm_cfg_if cfg_ch();
  svpwm_in_if  in_ch();
  svpwm_out_if out_ch();

  space_vector_pwm_timing_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  duty_set_t           pending_duties[$];
  duty_set_t           cur_duties;
  demand_row_t         demand_table[DIRECTED_ROWS];
  logic [PERIOD_W-1:0] period_r;
  int                  idle_pct;
  int                  stall_pct;
  bit                  hold_req;
  int                  mismatches;
  int                  result_idx;
  int                  quiet_cycles;

  function automatic duty_set_t center_aligned_duties(input logic signed [IN_W-1:0] alpha,
                                                      input logic signed [IN_W-1:0] beta,
                                                      input logic [PERIOD_W-1:0] period);
    longint alpha_s, half_b, vr1, vr2, vr3, vx, vy, p, xw, yw, s, tc_l;
    logic [DUTY_W-1:0] ta, tb, tc;
    duty_set_t r;
    p       = longint'(period);
    alpha_s = (longint'(alpha) * longint'(SQRT3_HALF_Q15)) >>> Q15_SHIFT;
    half_b  = (-longint'(beta)) / 2;
    vr1     = longint'(beta);
    vr2     = half_b + alpha_s;
    vr3     = half_b - alpha_s;
    if (vr1 >= 0) begin
      if (vr2 >= 0) begin
        r.sector = SECTOR_1; vx = vr2; vy = vr1;
      end else if (vr3 >= 0) begin
        r.sector = SECTOR_3; vx = vr1; vy = vr3;
      end else begin
        r.sector = SECTOR_2; vx = -vr2; vy = -vr3;
      end
    end else begin
      if (vr2 >= 0) begin
        if (vr3 >= 0) begin
          r.sector = SECTOR_5; vx = vr3; vy = vr2;
        end else begin
          r.sector = SECTOR_6; vx = -vr3; vy = -vr1;
        end
      end else begin
        r.sector = SECTOR_4; vx = -vr1; vy = -vr2;
      end
    end
    xw   = p * vx;
    yw   = p * vy;
    s    = (xw + yw) >>> Q15_SHIFT;
    tc_l = (p - s) / 2;
    tc   = tc_l[DUTY_W-1:0];
    tb   = tc + DUTY_W'(yw >>> Q15_SHIFT);
    ta   = tb + DUTY_W'(xw >>> Q15_SHIFT);
    r.overmod = (s > p);
    case (r.sector)
      SECTOR_1: begin r.duty_a = ta; r.duty_b = tb; r.duty_c = tc; end
      SECTOR_2: begin r.duty_a = tb; r.duty_b = ta; r.duty_c = tc; end
      SECTOR_3: begin r.duty_a = tc; r.duty_b = ta; r.duty_c = tb; end
      SECTOR_4: begin r.duty_a = tc; r.duty_b = tb; r.duty_c = ta; end
      SECTOR_5: begin r.duty_a = tb; r.duty_b = tc; r.duty_c = ta; end
      default:  begin r.duty_a = ta; r.duty_b = tc; r.duty_c = tb; end
    endcase
    return r;
  endfunction

  function automatic logic signed [IN_W-1:0] corner_demand();
    case ($urandom_range(4))
      0:       return 16'sh8000;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return 16'sh7FFF;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold when requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) pending_duties.push_back(cur_duties);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_duties.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result %0d: a=%0d b=%0d c=%0d sector=%0d om=%0b",
                     result_idx, out_ch.duty_a, out_ch.duty_b, out_ch.duty_c,
                     out_ch.sector_number, out_ch.overmodulated);
        end else begin
          duty_set_t w;
          w = pending_duties.pop_front();
          if (out_ch.duty_a !== w.duty_a || out_ch.duty_b !== w.duty_b ||
              out_ch.duty_c !== w.duty_c || out_ch.sector_number !== w.sector ||
              out_ch.overmodulated !== w.overmod) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("result %0d expected: a=%0d b=%0d c=%0d sector=%0d om=%0b",
                       result_idx, w.duty_a, w.duty_b, w.duty_c, w.sector, w.overmod);
              $display("result %0d actual:   a=%0d b=%0d c=%0d sector=%0d om=%0b",
                       result_idx, out_ch.duty_a, out_ch.duty_b, out_ch.duty_c,
                       out_ch.sector_number, out_ch.overmodulated);
            end
          end
        end
        result_idx++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_demand(input logic signed [IN_W-1:0] a,
                             input logic signed [IN_W-1:0] b,
                             input logic typed, input duty_set_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.v_alpha <= a;
    in_ch.v_beta  <= b;
    in_ch.valid   <= 1'b1;
    cur_duties = typed ? want : center_aligned_duties(a, b, period_r);
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] p);
    cfg_ch.timer_period <= p;
    cfg_ch.valid        <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    period_r = p;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [PERIOD_W-1:0] p, input int idle, input int stall,
                           input int items, input bit pressure);
    logic signed [IN_W-1:0] a, b;
    wait_for_results();
    write_period(p);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < items; i++) begin
      if (pressure && i == 20) hold_req = 1'b1;
      if (pressure && i == 70) wait_for_results();
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          a = IN_W'($urandom);
          b = IN_W'($urandom);
        end
        5, 6, 7: begin
          a = IN_W'(int'($urandom_range(36000)) - 18000);
          b = IN_W'(int'($urandom_range(36000)) - 18000);
        end
        8: begin
          a = IN_W'(int'($urandom_range(600)) - 300);
          b = IN_W'(int'($urandom_range(600)) - 300);
        end
        default: begin
          a = corner_demand();
          b = corner_demand();
        end
      endcase
      send_demand(a, b, 1'b0, '0);
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.v_alpha       <= '0;
    in_ch.v_beta        <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.timer_period <= '0;
    period_r     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    mismatches   = 0;
    result_idx   = 0;
    quiet_cycles = 0;

    demand_table = '{
      '{15'd0,     16'sd0,      16'sd0,      1'b1, '{16'd0, 16'd0, 16'd0, SECTOR_1, 1'b0}},
      '{15'd0,     16'sh7FFF,   16'sd0,      1'b1, '{16'd0, 16'd0, 16'd0, SECTOR_1, 1'b0}},
      '{15'd0,     16'sh8000,   16'sh8000,   1'b1, '{16'd0, 16'd0, 16'd0, SECTOR_4, 1'b0}},
      '{15'd32767, 16'sd0,      16'sd0,      1'b1,
        '{16'd16383, 16'd16383, 16'd16383, SECTOR_1, 1'b0}},
      '{15'd32767, 16'sd16000,  16'sd8000,   1'b0, '0},
      '{15'd32767, 16'sd0,      16'sd16000,  1'b0, '0},
      '{15'd32767, -16'sd16000, 16'sd8000,   1'b0, '0},
      '{15'd32767, -16'sd16000, -16'sd8000,  1'b0, '0},
      '{15'd32767, 16'sd0,      -16'sd16000, 1'b0, '0},
      '{15'd32767, 16'sd16000,  -16'sd8000,  1'b0, '0},
      '{15'd32767, 16'sh7FFF,   16'sh7FFF,   1'b0, '0},
      '{15'd32767, 16'sh8000,   16'sh8000,   1'b0, '0},
      '{15'd32767, 16'sh8000,   16'sh7FFF,   1'b0, '0},
      '{15'd32767, 16'sh7FFF,   16'sh8000,   1'b0, '0},
      '{15'd32767, -16'sd1,     16'sd0,      1'b0, '0},
      '{15'd32767, 16'sd0,      -16'sd1,     1'b0, '0},
      '{15'd32767, 16'sd0,      16'sd1,      1'b0, '0},
      '{15'd32767, 16'sd1,      -16'sd1,     1'b0, '0},
      '{15'd32767, 16'sd1,      16'sd0,      1'b0, '0},
      '{15'd1,     16'sd0,      16'sd0,      1'b1, '{16'd0, 16'd0, 16'd0, SECTOR_1, 1'b0}},
      '{15'd1,     16'sh7FFF,   16'sh7FFF,   1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (demand_table[r].period != period_r) begin
        wait_for_results();
        write_period(demand_table[r].period);
      end
      send_demand(demand_table[r].alpha, demand_table[r].beta,
                  demand_table[r].typed, demand_table[r].want);
    end

    run_phase(15'd32767, 0, 0, 130, 1'b1);
    run_phase(PERIOD_W'($urandom_range(2, 32766)), 75, 0, 120, 1'b0);
    run_phase(PERIOD_W'($urandom_range(2, 32766)), 0, 75, 120, 1'b0);
    run_phase(PERIOD_W'($urandom_range(2, 32766)), 34, 34, 110, 1'b0);
    run_phase(15'd0, 34, 34, 30, 1'b0);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
